@@ rtl/slfr_pkg.sv @@
// ----------------------------------------------------------------------------
// slfr_pkg: shared types and constants
// Item layouts and fixed values for the sync/length frame receiver.
// ----------------------------------------------------------------------------
package slfr_pkg;

	localparam logic [7:0]  SYNC_MARK     = 8'h80;
	localparam logic [8:0]  LENGTH_BIAS   = 9'd2;
	localparam logic [31:0] TIMEOUT_RESET = 32'd3277;

	localparam logic MODE_BYTE  = 1'b0;
	localparam logic MODE_ALLOC = 1'b1;

	typedef struct packed {
		logic        mode;
		logic [7:0]  rx_byte;
		logic [31:0] now_ticks;
	} slfr_in_item_t;

	typedef struct packed {
		logic [7:0]  frame_byte;
		logic [8:0]  byte_position;
		logic [31:0] frame_start_ticks;
		logic [8:0]  frame_total_length;
		logic        last;
	} slfr_out_item_t;

	typedef struct packed {
		logic           valid;
		slfr_out_item_t item;
	} slfr_result_t;

endpackage

@@ rtl/slfr_ifs.sv @@
// ----------------------------------------------------------------------------
// slfr_ifs: channel interfaces
// Valid/ready channels for input items, result items and the config write.
// ----------------------------------------------------------------------------
interface slfr_in_if import slfr_pkg::*; ();
	logic          valid;
	logic          ready;
	slfr_in_item_t item;
	modport source (output valid, output item, input ready);
	modport sink   (input valid, input item, output ready);
endinterface

interface slfr_out_if import slfr_pkg::*; ();
	logic           valid;
	logic           ready;
	slfr_out_item_t item;
	modport source (output valid, output item, input ready);
	modport sink   (input valid, input item, output ready);
endinterface

interface slfr_cfg_if ();
	logic        valid;
	logic        ready;
	logic [31:0] data;
	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

@@ rtl/slfr_in_stage.sv @@
// ----------------------------------------------------------------------------
// slfr_in_stage: input register
// Captures one request per cycle while the core is not stalled; holds it until the core consumes it.
// ----------------------------------------------------------------------------
module slfr_in_stage import slfr_pkg::*; (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	input  slfr_in_item_t in_item,
	output logic          in_ready,
	input  logic          advance,
	output logic          valid_s1,
	output slfr_in_item_t item_s1
);

	assign in_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			item_s1 <= in_item;
		end
	end

endmodule

@@ rtl/slfr_core.sv @@
// ----------------------------------------------------------------------------
// slfr_core: framing state and per-byte decision
// Hunts for sync, takes the length byte, tracks position and timeout.
// ----------------------------------------------------------------------------
module slfr_core import slfr_pkg::*; (
	input  logic          clk,
	input  logic          arst_n,
	input  slfr_in_item_t item_s1,
	input  logic          fire,
	input  logic          cfg_we,
	input  logic [31:0]   cfg_data,
	output slfr_result_t  res
);

	logic [31:0] timeout_q;
	logic [8:0]  position_q;
	logic        armed_q;
	logic [31:0] start_q;
	logic [8:0]  exp_len_q;
	logic        held_q;

	logic [31:0] elapsed;
	logic        timed_out;
	logic [8:0]  pos_eff;
	logic        armed_eff;
	logic        accept_byte;
	logic [31:0] start_nxt;
	logic [8:0]  exp_nxt;
	logic [8:0]  pos_inc;
	logic        is_last;

	always_comb begin
		elapsed     = item_s1.now_ticks - start_q;
		timed_out   = armed_q && (elapsed > timeout_q);
		pos_eff     = timed_out ? 9'd0 : position_q;
		armed_eff   = timed_out ? 1'b0 : armed_q;
		// at position 0 only the sync byte opens a frame
		accept_byte = (pos_eff != 9'd0) || (item_s1.rx_byte == SYNC_MARK);
		start_nxt   = (pos_eff == 9'd0) ? item_s1.now_ticks : start_q;
		exp_nxt     = (pos_eff == 9'd1) ? (LENGTH_BIAS + {1'b0, item_s1.rx_byte})
		                                : exp_len_q;
		pos_inc     = pos_eff + 9'd1;
		is_last     = (pos_inc >= 9'd2) && (pos_inc == exp_nxt);

		res.valid                   = fire && (item_s1.mode == MODE_BYTE) && held_q
		                              && accept_byte;
		res.item.frame_byte         = item_s1.rx_byte;
		res.item.byte_position      = pos_eff;
		res.item.frame_start_ticks  = start_nxt;
		res.item.frame_total_length = (pos_eff == 9'd0) ? 9'd0 : exp_nxt;
		res.item.last               = is_last;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			timeout_q  <= TIMEOUT_RESET;
			position_q <= '0;
			armed_q    <= 1'b0;
			start_q    <= '0;
			exp_len_q  <= '0;
			held_q     <= 1'b1;
		end else begin
			if (cfg_we) begin
				timeout_q <= cfg_data;
			end
			if (fire) begin
				if (item_s1.mode == MODE_ALLOC) begin
					held_q <= 1'b1;
				end else if (!held_q) begin
					position_q <= '0;
				end else if (!accept_byte) begin
					position_q <= '0;
					armed_q    <= armed_eff;
				end else begin
					start_q   <= start_nxt;
					exp_len_q <= exp_nxt;
					if (is_last) begin
						position_q <= '0;
						armed_q    <= 1'b0;
						held_q     <= 1'b0;
					end else begin
						position_q <= pos_inc;
						armed_q    <= 1'b1;
					end
				end
			end
		end
	end

	// completed frame gives up the buffer
	a_last_releases: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid && res.item.last |=> !held_q)
		else $error("buffer still held after last byte");

	// a sync result always leaves the frame open and armed; it never completes one
	a_sync_arms: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid && (res.item.byte_position == 9'd0) |=> armed_q && position_q == 9'd1)
		else $error("sync byte did not open a frame");

	// position 0 results carry the sync byte and no length
	a_sync_result: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid && (res.item.byte_position == 9'd0) |->
		(res.item.frame_byte == SYNC_MARK) && (res.item.frame_total_length == 9'd0))
		else $error("bad position 0 result");

	// without a buffer no result is produced
	a_no_buffer: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid |-> held_q)
		else $error("result emitted without a buffer");

endmodule

@@ rtl/slfr_out_buf.sv @@
// ----------------------------------------------------------------------------
// slfr_out_buf: result register
// Two-entry result queue; decouples the core from output stalls.
// ----------------------------------------------------------------------------
module slfr_out_buf import slfr_pkg::*; (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  slfr_out_item_t push_item,
	output logic           can_push,
	output logic           out_valid,
	output slfr_out_item_t out_item,
	input  logic           out_ready
);

	slfr_out_item_t mem_q [2];
	logic           wr_ptr_q;
	logic           rd_ptr_q;
	logic [1:0]     count_q;
	logic           pop;

	assign can_push  = (count_q != 2'd2);
	assign out_valid = (count_q != 2'd0);
	assign out_item  = mem_q[rd_ptr_q];
	assign pop       = out_valid && out_ready;

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> can_push)
		else $error("push into full result queue");

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q != 2'd3)
		else $error("result queue count out of range");

	a_stall_holds: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_item))
		else $error("stalled result changed");

endmodule

@@ rtl/sync_length_frame_receiver_top.sv @@
// ----------------------------------------------------------------------------
// sync_length_frame_receiver_top: sync/length framed byte receiver
// Cuts a timestamped byte stream into frames: sync 0x80, length, payload.
// ----------------------------------------------------------------------------
// Channels:
//   rx    - input requests: mode 0 carries a received byte with its tick
//           stamp, mode 1 tells the block a fresh receive buffer is ready.
//   frame - one result per accepted byte: byte, position (0 = sync),
//           sync timestamp, total length (from position 1) and last.
//   cfg   - write of frame_timeout_ticks; always ready, write while idle.
// Throughput: one request per cycle while the result queue has room. The only
//   loop is the framing state in the core, updated once per request.
// Path: from rx acceptance to frame valid a request passes the input register,
//   then the result queue.
// Requests that produce no result (allocate, dropped bytes) still pass
//   through the core in order and just leave the result queue untouched.
// Reset: position cleared and timer disarmed, buffer held, timeout = 3277 ticks,
//   both queues empty.
// Stall: when frame.ready is low the two-entry result queue fills, the
//   core pauses, rx.ready drops while a request is staged; nothing is lost.
// ----------------------------------------------------------------------------
module sync_length_frame_receiver_top import slfr_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	slfr_in_if.sink     rx,
	slfr_out_if.source  frame,
	slfr_cfg_if.sink    cfg
);

	logic          valid_s1;
	slfr_in_item_t item_s1;
	logic          advance;
	logic          can_push;
	slfr_result_t  res;
	logic          in_ready;

	// config is a plain register write, never stalls
	assign cfg.ready = 1'b1;

	// core consumes the staged request when a result slot is free
	assign advance  = valid_s1 && can_push;
	assign rx.ready = in_ready;

	slfr_in_stage u_in_stage (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (rx.valid),
		.in_item  (rx.item),
		.in_ready (in_ready),
		.advance  (advance),
		.valid_s1 (valid_s1),
		.item_s1  (item_s1)
	);

	slfr_core u_core (
		.clk      (clk),
		.arst_n   (arst_n),
		.item_s1  (item_s1),
		.fire     (advance),
		.cfg_we   (cfg.valid),
		.cfg_data (cfg.data),
		.res      (res)
	);

	slfr_out_buf u_out_buf (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (res.valid),
		.push_item (res.item),
		.can_push  (can_push),
		.out_valid (frame.valid),
		.out_item  (frame.item),
		.out_ready (frame.ready)
	);

endmodule

@@ dv/sync_length_frame_receiver_top_tb.sv @@
// ----------------------------------------------------------------------------
// sync_length_frame_receiver_top_tb: self-checking bench for the deframer
// Drives timestamped bytes and buffer allocations into the receiver, and
// predicts every emitted frame byte with a cycle-free model of the framing
// state. Results are checked field by field, in order. Covers hunting, short
// and maximum frames, timeout with wrap, buffer release, several timeout
// settings, random stalls on both sides and a long output hold-off.
// ----------------------------------------------------------------------------
module sync_length_frame_receiver_top_tb;
	import slfr_pkg::*;

	// cycles with no handshake on any channel before the run is called hung
	localparam int QUIET_LIMIT = 1500;
	// long output hold-off used to back the block up into its input
	localparam int HOLD_CYCLES = 200;
	// settle time after the last result; covers requests that give no result
	localparam int SETTLE_CYCLES = 8;

	// ------------------------------------------------------------------------
	// Scoreboard: keeps its own copy of the framing state and timeout, works
	// out the frame byte (if any) for each accepted request and checks the
	// block's results against the oldest pending one.
	// ------------------------------------------------------------------------
	class frame_byte_scoreboard;
		logic [31:0]    timeout_ticks;
		logic [8:0]     position;
		logic [8:0]     expected_length;
		logic [31:0]    start_ticks;
		logic           armed;
		logic           buffer_held;
		slfr_out_item_t expected_bytes[$];
		int             errors;
		int             requests;
		int             bytes_checked;
		int             frames_closed;
		int             timeouts_seen;

		function new();
			timeout_ticks   = TIMEOUT_RESET;
			position        = '0;
			expected_length = '0;
			start_ticks     = '0;
			armed           = 1'b0;
			buffer_held     = 1'b1;
			errors          = 0;
			requests        = 0;
			bytes_checked   = 0;
			frames_closed   = 0;
			timeouts_seen   = 0;
		endfunction

		function void set_timeout(logic [31:0] value);
			timeout_ticks = value;
		endfunction

		function int pending();
			return expected_bytes.size();
		endfunction

		function void note_request(slfr_in_item_t rq);
			logic [31:0]    elapsed;
			logic [8:0]     pos;
			logic [8:0]     nxt;
			slfr_out_item_t fb;
			requests++;
			if (rq.mode == MODE_ALLOC) begin
				buffer_held = 1'b1;
				return;
			end
			if (!buffer_held) begin
				position = '0;
				return;
			end
			elapsed = rq.now_ticks - start_ticks;
			if (armed && elapsed > timeout_ticks) begin
				position = '0;
				armed    = 1'b0;
				timeouts_seen++;
			end
			pos = position;
			if (pos == 9'd0) begin
				if (rq.rx_byte != SYNC_MARK)
					return;
				start_ticks = rq.now_ticks;
				armed       = 1'b1;
			end else if (pos == 9'd1) begin
				expected_length = LENGTH_BIAS + {1'b0, rq.rx_byte};
			end
			fb.frame_byte         = rq.rx_byte;
			fb.byte_position      = pos;
			fb.frame_start_ticks  = start_ticks;
			fb.frame_total_length = (pos == 9'd0) ? 9'd0 : expected_length;
			fb.last               = 1'b0;
			nxt = pos + 9'd1;
			if (nxt >= 9'd2 && nxt == expected_length) begin
				fb.last     = 1'b1;
				position    = '0;
				armed       = 1'b0;
				buffer_held = 1'b0;
				frames_closed++;
			end else begin
				position = nxt;
			end
			expected_bytes.push_back(fb);
		endfunction

		task report_mismatch(string what, logic [31:0] got, logic [31:0] want);
			errors++;
			$display("mismatch at %0t: %s got 0x%0h want 0x%0h", $time, what, got, want);
		endtask

		task check_result(slfr_out_item_t got);
			slfr_out_item_t want;
			if (expected_bytes.size() == 0) begin
				report_mismatch("unexpected frame byte", 32'(got.frame_byte), 32'd0);
				return;
			end
			want = expected_bytes.pop_front();
			bytes_checked++;
			if (got.frame_byte !== want.frame_byte)
				report_mismatch("frame_byte", 32'(got.frame_byte),
					32'(want.frame_byte));
			if (got.byte_position !== want.byte_position)
				report_mismatch("byte_position", 32'(got.byte_position),
					32'(want.byte_position));
			if (got.frame_start_ticks !== want.frame_start_ticks)
				report_mismatch("frame_start_ticks", got.frame_start_ticks,
					want.frame_start_ticks);
			if (got.frame_total_length !== want.frame_total_length)
				report_mismatch("frame_total_length", 32'(got.frame_total_length),
					32'(want.frame_total_length));
			if (got.last !== want.last)
				report_mismatch("last", 32'(got.last), 32'(want.last));
		endtask
	endclass

	logic clk    = 1'b0;
	logic arst_n = 1'b0;

	slfr_in_if  rx_if ();
	slfr_out_if frame_if ();
	slfr_cfg_if cfg_if ();

	sync_length_frame_receiver_top dut (
		.clk    (clk),
		.arst_n (arst_n),
		.rx     (rx_if),
		.frame  (frame_if),
		.cfg    (cfg_if)
	);

	always #6 clk = ~clk;

	frame_byte_scoreboard sb;

	bit          idle_on      = 1'b1;  // random gaps and stalls on both sides
	bit          hold_request = 1'b0;  // asks the sink for one long hold-off
	logic [31:0] cur_timeout  = TIMEOUT_RESET;
	int unsigned tick_step    = 12;    // largest tick advance between bytes
	int          stream_items = 0;     // well-formed requests sent so far
	int          settings_run = 1;
	int          quiet_cycles = 0;

	// ------------------------------------------------------------------------
	// Monitor and watchdog. Everything is sampled at the rising edge, before
	// any nonblocking update of that edge lands, so handshakes are seen
	// exactly as the block sees them.
	// ------------------------------------------------------------------------
	always @(posedge clk) begin
		bit moved;
		moved = 1'b0;
		if (arst_n) begin
			if (cfg_if.valid && cfg_if.ready) begin
				sb.set_timeout(cfg_if.data);
				moved = 1'b1;
			end
			if (rx_if.valid && rx_if.ready) begin
				sb.note_request(rx_if.item);
				moved = 1'b1;
			end
			if (frame_if.valid && frame_if.ready) begin
				sb.check_result(frame_if.item);
				moved = 1'b1;
			end
		end
		quiet_cycles = moved ? 0 : quiet_cycles + 1;
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("watchdog: no handshake for %0d cycles, %0d frame bytes outstanding",
				QUIET_LIMIT, sb.pending());
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	// ------------------------------------------------------------------------
	// Result sink: ready in random stretches, random stall bursts while idling
	// is on, and one long hold-off on request. One ready update per step.
	// ------------------------------------------------------------------------
	initial begin : result_sink
		frame_if.ready <= 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if (hold_request) begin
				frame_if.ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_request = 1'b0;
			end else if (idle_on && $urandom_range(0, 4) == 0) begin
				frame_if.ready <= 1'b0;
				repeat ($urandom_range(1, 11)) @(posedge clk);
			end else begin
				frame_if.ready <= 1'b1;
				repeat ($urandom_range(1, 12)) @(posedge clk);
			end
		end
	end

	// one request on rx; returns at the edge where it was taken, valid still
	// high so back-to-back requests keep the channel busy
	task automatic send_request(input logic mode, input logic [7:0] data,
			input logic [31:0] ticks);
		slfr_in_item_t rq;
		int            gap;
		rq.mode      = mode;
		rq.rx_byte   = data;
		rq.now_ticks = ticks;
		if (idle_on && $urandom_range(0, 5) == 0) begin
			gap = $urandom_range(1, 11);
			rx_if.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		rx_if.item  <= rq;
		rx_if.valid <= 1'b1;
		@(posedge clk);
		while (!rx_if.ready) @(posedge clk);
	endtask

	task automatic send_byte(input logic [7:0] data, input logic [31:0] ticks);
		send_request(MODE_BYTE, data, ticks);
	endtask

	// allocate: byte and tick fields are don't-care, so fill them randomly
	task automatic send_alloc();
		send_request(MODE_ALLOC, 8'($urandom_range(0, 255)), $urandom());
	endtask

	// stop offering, wait for every predicted byte, then let requests that
	// give no result clear the pipeline; the first edge lets the monitor
	// note the last request before the queue is looked at
	task automatic wait_drained();
		rx_if.valid <= 1'b0;
		@(posedge clk);
		while (sb.pending() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// only called with the block drained
	task automatic write_timeout(input logic [31:0] value, input int unsigned step);
		cfg_if.data  <= value;
		cfg_if.valid <= 1'b1;
		@(posedge clk);
		while (!cfg_if.ready) @(posedge clk);
		cfg_if.valid <= 1'b0;
		cur_timeout = value;
		tick_step   = step;
		settings_run++;
	endtask

	// allocate, sync, length, payload. A messy frame may skip the allocate
	// and may jump past the timeout partway, so the tail turns into noise
	// that the block has to hunt through.
	task automatic send_frame(input logic [7:0] len_byte, input bit messy);
		logic [31:0] t;
		logic [31:0] t_sync;
		int          k;
		t      = $urandom();
		t_sync = t;
		if (!messy || $urandom_range(0, 9) != 0) begin
			send_alloc();
			stream_items++;
		end
		send_byte(SYNC_MARK, t);
		t += $urandom_range(0, tick_step);
		send_byte(len_byte, t);
		stream_items += 2;
		for (k = 0; k < int'(len_byte); k++) begin
			if (messy && cur_timeout != '1 && $urandom_range(0, 59) == 0)
				t = t_sync + cur_timeout + 32'd1 + $urandom_range(0, 3);
			else
				t += $urandom_range(0, tick_step);
			send_byte(8'($urandom_range(0, 255)), t);
			stream_items++;
		end
	endtask

	// line noise: stray bytes (sync value included), stray allocates, wild ticks
	task automatic send_noise();
		int n;
		n = $urandom_range(1, 4);
		repeat (n) begin
			if ($urandom_range(0, 5) == 0)
				send_alloc();
			else if ($urandom_range(0, 3) == 0)
				send_byte(SYNC_MARK, $urandom());
			else
				send_byte(8'($urandom_range(0, 255)), $urandom());
		end
	endtask

	task automatic random_traffic(input int count);
		int         target;
		logic [7:0] len_byte;
		target = stream_items + count;
		while (stream_items < target) begin
			if ($urandom_range(0, 9) == 0) begin
				send_noise();
			end else begin
				// mostly short frames, now and then a long one
				if ($urandom_range(0, 39) == 0)
					len_byte = 8'($urandom_range(100, 255));
				else
					len_byte = 8'($urandom_range(0, 10));
				send_frame(len_byte, 1'b1);
			end
		end
	endtask

	// ------------------------------------------------------------------------
	// Stimulus sequence
	// ------------------------------------------------------------------------
	initial begin : stimulus
		sb = new();
		rx_if.valid  <= 1'b0;
		rx_if.item   <= '0;
		cfg_if.valid <= 1'b0;
		cfg_if.data  <= '0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: reset timeout of 3277 ticks
		send_byte(8'h00, 32'h0000_0000);           // hunting, dropped
		send_byte(8'hFF, 32'hFFFF_FFFF);           // hunting, dropped
		send_byte(SYNC_MARK, 32'hFFFF_FFF0);
		send_byte(8'h00, 32'hFFFF_FFF1);           // length 0: two-byte frame, last
		send_byte(SYNC_MARK, 32'hFFFF_FFF2);       // buffer released, dropped
		send_request(MODE_ALLOC, 8'hFF, 32'hFFFF_FFFF);
		send_byte(SYNC_MARK, 32'hFFFF_FFF8);
		send_byte(8'h01, 32'hFFFF_FFFC);
		send_byte(8'hFF, 32'h0000_0004);           // tick wrap, still in time, last
		send_request(MODE_ALLOC, 8'h00, 32'h0000_0000);
		send_byte(SYNC_MARK, 32'h1000_0000);
		send_byte(8'h05, 32'h1000_0001);
		send_byte(SYNC_MARK, 32'h1000_0CCE);       // one past timeout: new sync
		send_byte(8'h02, 32'h1000_0CCF);
		send_alloc();                              // mid-frame allocate, no effect
		send_byte(SYNC_MARK, 32'h1000_199B);       // exactly at timeout: kept
		send_byte(8'h55, 32'h1000_199B);           // last
		send_alloc();
		send_byte(8'h7F, 32'h2000_0000);           // near miss on sync
		send_byte(SYNC_MARK, 32'h0000_0000);
		send_byte(8'h03, 32'h0000_0001);
		send_byte(SYNC_MARK, 32'h0000_0002);       // sync value as payload
		send_byte(8'hAA, 32'h0000_0003);
		send_byte(8'h00, 32'h0000_0004);           // last
		random_traffic(120);
		wait_drained();

		// zero timeout: any tick advance after sync abandons the frame
		write_timeout(32'h0000_0000, 0);
		random_traffic(60);
		wait_drained();

		// timeout never fires; includes one frame of the greatest length
		write_timeout(32'hFFFF_FFFF, 1000000);
		send_frame(8'hFF, 1'b0);
		random_traffic(40);
		wait_drained();

		// mid-range random timeout
		begin
			logic [31:0] tmo;
			tmo = $urandom_range(300, 6000);
			write_timeout(tmo, tmo / 300);
		end
		random_traffic(80);
		wait_drained();

		// back-pressure: the sink holds off while the sender keeps pushing
		idle_on      = 1'b0;
		hold_request = 1'b1;
		send_frame(8'd40, 1'b0);
		wait_drained();

		// closing stretch at the reset timeout, no idling on either side
		write_timeout(TIMEOUT_RESET, 12);
		random_traffic(40);
		wait_drained();

		$display("run covered %0d requests, %0d frame bytes checked, %0d frames closed",
			sb.requests, sb.bytes_checked, sb.frames_closed);
		$display("%0d timeout settings (zero and all-ones among them), %0d timeouts hit",
			settings_run, sb.timeouts_seen);
		if (sb.errors == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule
